### rtl/core/iah_pkg.sv
// Package: shared types, constants and codes for the integer ALU with history ring.
package iah_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 10;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] OP_ADD  = 8'h2B;
    localparam logic [7:0] OP_SUB  = 8'h2D;
    localparam logic [7:0] OP_MULX = 8'h78;
    localparam logic [7:0] OP_MUL  = 8'h2A;
    localparam logic [7:0] OP_DIV  = 8'h2F;
    localparam logic [7:0] OP_MOD  = 8'h25;

    typedef enum logic [1:0] {
        MODE_COMPUTE = 2'd0,
        MODE_RECALL  = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_LIST    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIV_ZERO = 3'd1,
        ST_BAD_OP   = 3'd2,
        ST_BAD_POS  = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DIV,
        S_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;     // capture input payload
        logic read_ent;    // read ring entry at pos_reg into operands
        logic start_eval;  // evaluate operands (start divider if needed)
        logic div_step;    // one divider iteration
        logic finish;      // form the result into the output register
        logic store;       // push current operands into the ring
        logic clear;       // empty the ring
        logic next_pos;    // advance list position
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_div;      // evaluated op needs the divider
        logic div_done;
        logic eval_ok;
        logic list_more;   // more list entries follow
    } dp_stat_t;

    function automatic logic op_known(input logic [7:0] op);
        return op == OP_ADD || op == OP_SUB || op == OP_MULX || op == OP_MUL
            || op == OP_DIV || op == OP_MOD;
    endfunction

endpackage

### rtl/core/integer_alu_with_history_ring.sv
// Top level: integer ALU with a ring of recent successful operations.
// Divide and modulo use the one-bit-per-cycle restoring divider; list mode
// repeats the transfer per entry. The block takes one item at a time. Mode 0
// computes, 1 recalls a 1-based entry counted from the oldest, 2 clears the
// ring, 3 lists all entries with last on the final one.
module integer_alu_with_history_ring #(
    parameter int unsigned HISTORY_DEPTH = iah_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] operand_a,
    input  logic [7:0]         op_char,
    input  logic signed [31:0] operand_b,
    input  logic [7:0]         recall_position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] value,
    output logic signed [31:0] entry_left,
    output logic [7:0]         entry_operator,
    output logic signed [31:0] entry_right,
    output logic [3:0]         entry_position,
    output logic               last
);
    iah_pkg::dp_cmd_t  cmd;
    iah_pkg::dp_stat_t stat;
    logic [1:0]        mode_q;

    iah_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .mode_q(mode_q), .stat(stat), .cmd(cmd)
    );

    iah_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_mode(mode), .in_a(operand_a), .in_op(op_char), .in_b(operand_b),
        .in_pos(recall_position), .mode_q(mode_q),
        .res_status(status), .res_value(value), .res_left(entry_left),
        .res_operator(entry_operator), .res_right(entry_right),
        .res_position(entry_position), .res_last(last)
    );

`ifndef SYNTHESIS
    // No input is taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready while result pending");
    // A store never coincides with a clear
    a_store_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store && cmd.clear)) else $error("store and clear together");
    // An input transfer is followed by a quiet output
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
`endif
endmodule

### rtl/core/iah_datapath.sv
// Datapath: history ring, operand registers, multiplier, iterative divider, result register.
module iah_datapath #(
    parameter int unsigned HISTORY_DEPTH = iah_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iah_pkg::dp_cmd_t       cmd,
    output iah_pkg::dp_stat_t      stat,
    input  logic [1:0]             in_mode,
    input  logic signed [31:0]     in_a,
    input  logic [7:0]             in_op,
    input  logic signed [31:0]     in_b,
    input  logic [7:0]             in_pos,
    output logic [1:0]             mode_q,
    output logic [2:0]             res_status,
    output logic signed [31:0]     res_value,
    output logic signed [31:0]     res_left,
    output logic [7:0]             res_operator,
    output logic signed [31:0]     res_right,
    output logic [3:0]             res_position,
    output logic                   res_last
);
    localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic [31:0] left_mem  [HISTORY_DEPTH];
    logic [7:0]  oper_mem  [HISTORY_DEPTH];
    logic [31:0] right_mem [HISTORY_DEPTH];

    logic [IW-1:0] wp_reg;
    logic [PW-1:0] fill_reg;
    logic [1:0]    mode_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   a_reg, b_reg;
    logic [7:0]    op_reg;
    logic [31:0]   rd_a_reg, rd_b_reg;
    logic [7:0]    rd_op_reg;
    logic [31:0]   quot_reg, rem_reg, dvsr_reg;
    logic [5:0]    cnt_reg;
    logic          na_reg, nb_reg;
    logic [31:0]   arith_reg;
    logic          is_div_reg;
    logic [2:0]    eval_st_reg;

    assign mode_q = mode_reg;

    // Physical slot of list/recall position
    logic [PW:0]   slot_sum;
    logic [IW-1:0] slot;
    logic [PW-1:0] pos_n;
    assign pos_n = pos_reg[PW-1:0];
    always_comb
    begin
        slot_sum = {1'b0, pos_n} - 1'b1;
        if (fill_reg == PW'(HISTORY_DEPTH))
            slot_sum = slot_sum + (PW+1)'(wp_reg);
        if (slot_sum >= (PW+1)'(HISTORY_DEPTH))
            slot_sum = slot_sum - (PW+1)'(HISTORY_DEPTH);
        slot = slot_sum[IW-1:0];
    end

    // Ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            left_mem[wp_reg]  <= a_reg;
            oper_mem[wp_reg]  <= op_reg;
            right_mem[wp_reg] <= b_reg;
        end
        if (cmd.read_ent)
        begin
            rd_a_reg  <= left_mem[slot];
            rd_op_reg <= oper_mem[slot];
            rd_b_reg  <= right_mem[slot];
        end
    end

    // Ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (cmd.clear)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (cmd.store)
        begin
            wp_reg <= (wp_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != PW'(HISTORY_DEPTH))
                fill_reg <= fill_reg + 1'b1;
        end
    end

    logic recall_bad;
    assign recall_bad = (pos_reg == '0) || (pos_reg > 8'(fill_reg));

    // Ring entry holds a written operation only for a valid recall or a non-empty list
    logic ent_ok;
    assign ent_ok = ((mode_reg == iah_pkg::MODE_LIST) && (fill_reg != '0))
                 || ((mode_reg == iah_pkg::MODE_RECALL) && !recall_bad);

    // Operands for evaluation: input for compute, ring entry when ent_ok, zero otherwise
    logic [31:0] ea, eb;
    logic [7:0]  eop;
    assign ea  = (mode_reg == iah_pkg::MODE_COMPUTE) ? a_reg
               : (ent_ok ? rd_a_reg : '0);
    assign eb  = (mode_reg == iah_pkg::MODE_COMPUTE) ? b_reg
               : (ent_ok ? rd_b_reg : '0);
    assign eop = (mode_reg == iah_pkg::MODE_COMPUTE) ? op_reg
               : (ent_ok ? rd_op_reg : '0);

    logic eop_div;
    assign eop_div = (eop == iah_pkg::OP_DIV) || (eop == iah_pkg::OP_MOD);

    // Restoring divider step on magnitudes
    logic [32:0] trial;
    assign trial = {rem_reg, quot_reg[31]} - {1'b0, dvsr_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= in_mode;
            a_reg    <= in_a;
            op_reg   <= in_op;
            b_reg    <= in_b;
            // list always walks from the oldest entry
            pos_reg  <= (in_mode == iah_pkg::MODE_LIST) ? 8'd1 : in_pos;
        end
        if (cmd.next_pos)
            pos_reg <= pos_reg + 1'b1;
        if (cmd.start_eval)
        begin
            is_div_reg <= eop_div && (eb != '0);
            na_reg     <= ea[31];
            nb_reg     <= eb[31];
            quot_reg   <= ea[31] ? 32'(-ea) : ea;
            dvsr_reg   <= eb[31] ? 32'(-eb) : eb;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            unique case (eop)
                iah_pkg::OP_ADD: arith_reg <= ea + eb;
                iah_pkg::OP_SUB: arith_reg <= ea - eb;
                iah_pkg::OP_MUL, iah_pkg::OP_MULX: arith_reg <= 32'(ea * eb);
                default: arith_reg <= '0;
            endcase
            if (!iah_pkg::op_known(eop))
                eval_st_reg <= iah_pkg::ST_BAD_OP;
            else if (eop_div && eb == '0)
                eval_st_reg <= iah_pkg::ST_DIV_ZERO;
            else
                eval_st_reg <= iah_pkg::ST_OK;
        end
        else if (cmd.div_step)
        begin
            if (!trial[32])
            begin
                rem_reg  <= trial[31:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[30:0], quot_reg[31]};
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Final value of the evaluation
    logic [31:0] eval_val;
    always_comb
    begin
        if (eval_st_reg != iah_pkg::ST_OK)
            eval_val = '0;
        else if (!is_div_reg)
            eval_val = arith_reg;
        else if (eop == iah_pkg::OP_DIV)
            eval_val = (na_reg ^ nb_reg) ? 32'(-quot_reg) : quot_reg;
        else
            eval_val = na_reg ? 32'(-rem_reg) : rem_reg;
    end

    assign stat.is_div    = is_div_reg;
    assign stat.div_done  = (cnt_reg == 6'd32);
    assign stat.eval_ok   = (eval_st_reg == iah_pkg::ST_OK);
    assign stat.list_more = (mode_reg == iah_pkg::MODE_LIST) && (pos_reg < 8'(fill_reg));

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status   <= '0;
            res_value    <= '0;
            res_left     <= '0;
            res_operator <= '0;
            res_right    <= '0;
            res_position <= '0;
            res_last     <= 1'b1;
            unique case (mode_reg)
                iah_pkg::MODE_COMPUTE:
                begin
                    res_status <= eval_st_reg;
                    res_value  <= eval_val;
                end
                iah_pkg::MODE_CLEAR:
                    res_status <= iah_pkg::ST_CLEARED;
                iah_pkg::MODE_RECALL, iah_pkg::MODE_LIST:
                begin
                    if (mode_reg == iah_pkg::MODE_LIST && fill_reg == '0)
                        res_status <= iah_pkg::ST_EMPTY;
                    else if (mode_reg == iah_pkg::MODE_RECALL && recall_bad)
                        res_status <= iah_pkg::ST_BAD_POS;
                    else
                    begin
                        res_status   <= eval_st_reg;
                        res_value    <= eval_val;
                        res_left     <= rd_a_reg;
                        res_operator <= rd_op_reg;
                        res_right    <= rd_b_reg;
                        res_position <= pos_reg[3:0];
                        res_last     <= !((mode_reg == iah_pkg::MODE_LIST)
                                          && (pos_reg < 8'(fill_reg)));
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/iah_control.sv
// Controller: sequences load, ring read, evaluation, division and result transfer.
module iah_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         mode_q,
    input  iah_pkg::dp_stat_t  stat,
    output iah_pkg::dp_cmd_t   cmd
);
    iah_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iah_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iah_pkg::S_IDLE:
                if (in_valid)
                    state_next = iah_pkg::S_READ;
            iah_pkg::S_READ:
                state_next = iah_pkg::S_EVAL;
            iah_pkg::S_EVAL:
                state_next = iah_pkg::S_DIV;
            iah_pkg::S_DIV:
                if (!stat.is_div || stat.div_done)
                    state_next = iah_pkg::S_OUT;
            iah_pkg::S_OUT:
                if (out_ready)
                    state_next = stat.list_more ? iah_pkg::S_READ : iah_pkg::S_IDLE;
            default:
                state_next = iah_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            iah_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            iah_pkg::S_READ:
                cmd.read_ent = 1'b1;
            iah_pkg::S_EVAL:
                cmd.start_eval = 1'b1;
            iah_pkg::S_DIV:
            begin
                cmd.div_step = stat.is_div && !stat.div_done;
                if (!stat.is_div || stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    cmd.store  = (mode_q == iah_pkg::MODE_COMPUTE) && stat.eval_ok;
                    cmd.clear  = (mode_q == iah_pkg::MODE_CLEAR);
                end
            end
            iah_pkg::S_OUT:
            begin
                out_valid    = 1'b1;
                cmd.next_pos = out_ready && stat.list_more;
            end
            default: ;
        endcase
    end
endmodule

### test/tb_integer_alu_with_history_ring.sv
// Testbench: integer ALU with history ring, random and directed stimulus with a predictor.
`timescale 1ns / 1ps

module tb_integer_alu_with_history_ring;

    localparam int DEPTH = iah_pkg::HISTORY_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  md;
        logic [31:0] a;
        logic [7:0]  op;
        logic [31:0] b;
        logic [7:0]  pos;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
        logic [31:0] el;
        logic [7:0]  eop;
        logic [31:0] er;
        logic [3:0]  epos;
        logic        lst;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic signed [31:0] operand_a = '0;
    logic [7:0] op_char = '0;
    logic signed [31:0] operand_b = '0;
    logic [7:0] recall_position = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic signed [31:0] value;
    logic signed [31:0] entry_left;
    logic [7:0] entry_operator;
    logic signed [31:0] entry_right;
    logic [3:0] entry_position;
    logic last;

    integer_alu_with_history_ring dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cmd_item_t pending_cmds[$];
    alu_result_t expected_results[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit stim_done = 0;
    bit drain_request = 0;
    bit in_ready_seen = 0;

    // predictor copy of the ring
    logic [31:0] ring_left [DEPTH];
    logic [7:0]  ring_op [DEPTH];
    logic [31:0] ring_right [DEPTH];
    int ring_wr = 0;
    int ring_fill = 0;

    function automatic logic [2:0] alu_eval(input logic [31:0] a, input logic [7:0] op,
                                            input logic [31:0] b, output logic [31:0] res);
        logic [31:0] ma, mb, q, r;
        res = '0;
        case (op)
            iah_pkg::OP_ADD: res = a + b;
            iah_pkg::OP_SUB: res = a - b;
            iah_pkg::OP_MUL, iah_pkg::OP_MULX: res = a * b;
            iah_pkg::OP_DIV, iah_pkg::OP_MOD:
            begin
                if (b == 0) return iah_pkg::ST_DIV_ZERO;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = ma % mb;
                if (op == iah_pkg::OP_DIV) res = (a[31] ^ b[31]) ? -q : q;
                else res = a[31] ? -r : r;
            end
            default: return iah_pkg::ST_BAD_OP;
        endcase
        return iah_pkg::ST_OK;
    endfunction

    function automatic alu_result_t ring_entry(input int p, input logic lst);
        alu_result_t e;
        int s;
        s = ((ring_fill < DEPTH ? 0 : ring_wr) + p - 1) % DEPTH;
        e.st = alu_eval(ring_left[s], ring_op[s], ring_right[s], e.val);
        e.el = ring_left[s];
        e.eop = ring_op[s];
        e.er = ring_right[s];
        e.epos = p[3:0];
        e.lst = lst;
        return e;
    endfunction

    task automatic predict_cmd(input cmd_item_t c);
        alu_result_t e;
        e = '0;
        e.lst = 1'b1;
        case (iah_pkg::mode_t'(c.md))
            iah_pkg::MODE_COMPUTE:
            begin
                e.st = alu_eval(c.a, c.op, c.b, e.val);
                if (e.st == iah_pkg::ST_OK)
                begin
                    ring_left[ring_wr] = c.a;
                    ring_op[ring_wr] = c.op;
                    ring_right[ring_wr] = c.b;
                    ring_wr = (ring_wr + 1) % DEPTH;
                    if (ring_fill < DEPTH) ring_fill++;
                end
                else e.val = '0;
                expected_results.push_back(e);
            end
            iah_pkg::MODE_RECALL:
            begin
                if (c.pos == 0 || c.pos > ring_fill)
                begin
                    e.st = iah_pkg::ST_BAD_POS;
                    expected_results.push_back(e);
                end
                else expected_results.push_back(ring_entry(c.pos, 1'b1));
            end
            iah_pkg::MODE_CLEAR:
            begin
                ring_fill = 0;
                ring_wr = 0;
                e.st = iah_pkg::ST_CLEARED;
                expected_results.push_back(e);
            end
            default:
            begin
                if (ring_fill == 0)
                begin
                    e.st = iah_pkg::ST_EMPTY;
                    expected_results.push_back(e);
                end
                else
                    for (int i = 1; i <= ring_fill; i++)
                        expected_results.push_back(ring_entry(i, i == ring_fill));
            end
        endcase
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    function automatic cmd_item_t mk(input iah_pkg::mode_t m, input logic [31:0] a,
                                     input logic [7:0] op, input logic [31:0] b,
                                     input logic [7:0] p);
        cmd_item_t c;
        c.md = m; c.a = a; c.op = op; c.b = b; c.pos = p;
        return c;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_item_t rand_cmd();
        logic [7:0] ops [6] = '{iah_pkg::OP_ADD, iah_pkg::OP_SUB, iah_pkg::OP_MULX,
                                iah_pkg::OP_MUL, iah_pkg::OP_DIV, iah_pkg::OP_MOD};
        cmd_item_t c;
        c.a = rand_operand();
        c.b = rand_operand();
        c.op = ($urandom_range(0, 7) == 0) ? 8'($urandom) : ops[$urandom_range(0, 5)];
        c.pos = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        case ($urandom_range(0, 19))
            0: c.md = iah_pkg::MODE_CLEAR;
            1, 2: c.md = iah_pkg::MODE_LIST;
            3, 4, 5, 6: c.md = iah_pkg::MODE_RECALL;
            default: c.md = iah_pkg::MODE_COMPUTE;
        endcase
        return c;
    endfunction

    // directed then random stimulus, closed by a directed list
    initial
    begin
        pending_cmds.push_back(mk(iah_pkg::MODE_LIST, 0, iah_pkg::OP_ADD, 0, 1));
        pending_cmds.push_back(mk(iah_pkg::MODE_RECALL, 0, iah_pkg::OP_ADD, 0, 1));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'h7FFF_FFFF, iah_pkg::OP_ADD, 1, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'h8000_0000, iah_pkg::OP_SUB, 1, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'h8000_0000, iah_pkg::OP_MULX, -1, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 12345, iah_pkg::OP_MUL, -678, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'h8000_0000, iah_pkg::OP_DIV, -1, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'h8000_0000, iah_pkg::OP_MOD, -1, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, -7, iah_pkg::OP_DIV, 2, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, -7, iah_pkg::OP_MOD, 2, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 5, iah_pkg::OP_DIV, 0, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 5, iah_pkg::OP_MOD, 0, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 5, 8'hFF, 3, 8'hFF));
        pending_cmds.push_back(mk(iah_pkg::MODE_RECALL, 0, iah_pkg::OP_ADD, 0, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_RECALL, 0, iah_pkg::OP_ADD, 0, 3));
        pending_cmds.push_back(mk(iah_pkg::MODE_RECALL, 0, iah_pkg::OP_ADD, 0, 7));
        pending_cmds.push_back(mk(iah_pkg::MODE_RECALL, 0, iah_pkg::OP_ADD, 0, 8'hFF));
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(iah_pkg::MODE_COMPUTE, 32'($urandom),
                                      iah_pkg::OP_ADD, i, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_LIST, 0, iah_pkg::OP_ADD, 0, 0));
        pending_cmds.push_back(mk(iah_pkg::MODE_CLEAR, 0, iah_pkg::OP_ADD, 0, 0));
        for (int i = 0; i < 75; i++)
            pending_cmds.push_back(rand_cmd());
        pending_cmds.push_back(mk(iah_pkg::MODE_LIST, 0, iah_pkg::OP_ADD, 0, 0));
    end

    // driver
    int in_gap = 0;
    int sent = 0;
    always @(negedge clk)
    begin
        logic valid_next;
        logic ready_next;
        if (rst_n)
        begin
            valid_next = in_valid;
            if (in_valid && in_ready_seen)
            begin
                valid_next = 1'b0;
                in_gap = gap_len();
            end
            if (!in_valid || in_ready_seen)
            begin
                if (drain_request && expected_results.size() == 0)
                    drain_request = 0;
                if (in_gap > 0)
                    in_gap--;
                else if (!drain_request && pending_cmds.size() > 0)
                begin
                    cmd_item_t c;
                    c = pending_cmds.pop_front();
                    mode <= c.md;
                    operand_a <= c.a;
                    op_char <= c.op;
                    operand_b <= c.b;
                    recall_position <= c.pos;
                    valid_next = 1'b1;
                    sent++;
                    if (sent == 40) drain_request = 1;
                end
                else if (pending_cmds.size() == 0 && !drain_request)
                    stim_done = 1;
            end
            in_valid <= valid_next;
            ready_next = ($urandom_range(0, 9) < 7) ? 1'b1
                       : ($urandom_range(0, 3) == 0 ? 1'b0 : 1'b1);
            if ($urandom_range(0, 30) == 0) ready_next = 1'b0;
            out_ready <= ready_next;
        end
    end

    // acceptance seen at the rising edge; predictor runs there
    always @(posedge clk)
    begin
        cycle_count++;
        in_ready_seen = 0;
        if (rst_n && in_valid && in_ready)
        begin
            in_ready_seen = 1;
            predict_cmd({mode, operand_a, op_char, operand_b, recall_position});
        end
    end

    // monitor
    always @(posedge clk)
    begin
        alu_result_t got, exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, value, entry_left, entry_operator, entry_right, entry_position, last};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: st %0d/%0d val %h/%h el %h/%h op %h/%h ",
                                  "er %h/%h pos %0d/%0d last %b/%b"},
                                 exp_r.st, got.st, exp_r.val, got.val, exp_r.el, got.el,
                                 exp_r.eop, got.eop, exp_r.er, got.er, exp_r.epos, got.epos,
                                 exp_r.lst, got.lst);
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        while (!(stim_done && !in_valid && expected_results.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
        end
        else
        begin
            repeat (50) @(posedge clk);
            if (mismatch_count == 0 && expected_results.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
